// ----- rtl/spline_curve_point_eval_assert.svh -----
// ============================================================================
// Assertion macros for the curve point evaluator
// Short forms for the concurrent checks placed at the end of the top RTL file.
// ============================================================================
`ifndef SPLINE_CURVE_POINT_EVAL_ASSERT_SVH
`define SPLINE_CURVE_POINT_EVAL_ASSERT_SVH

// Checks that cons holds in the same cycle as ante, outside of reset.
`define SCPE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("curve point evaluator check failed");

// Checks that cons holds in the cycle after ante, outside of reset.
`define SCPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("curve point evaluator check failed");

`endif

// ----- rtl/scpe_pkg.sv -----
// ============================================================================
// Curve point evaluator package
// Shared constants, register indexes, the curve mode type and the control
// bundle that the top level hands to each coordinate lane.
// ============================================================================
package scpe_pkg;

    // Default formats: signed Q8.8 coordinates, unsigned Q1.16 parameter.
    localparam int COORD_WIDTH_DEF = 16;
    localparam int T_FRAC_BITS_DEF = 16;

    // Three coordinates per point: x, y, z (x in the low bits).
    localparam int NUM_AXES = 3;

    // Register stages from the input register to the output register.
    localparam int NUM_STAGES = 8;

    // Configuration register indexes.
    localparam int CFG_INDEX_WIDTH = 3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CURVE_MODE = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_POINT_A    = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_POINT_B    = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_POINT_C    = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_POINT_D    = 3'd4;

    typedef enum logic [1:0] {
        MODE_LINEAR  = 2'd0,
        MODE_QUAD    = 2'd1,
        MODE_CUBIC   = 2'd2,
        MODE_CATMULL = 2'd3
    } curve_mode_t;

    localparam curve_mode_t MODE_RESET = MODE_CUBIC;

    // Control that every coordinate lane receives from the top level.
    typedef struct packed {
        curve_mode_t            mode;
        logic [NUM_STAGES-1:0]  load;
    } lane_ctrl_t;

endpackage

// ----- rtl/scpe_sample_if.sv -----
// ============================================================================
// Parameter sample channel
// Carries one curve parameter t per item with a valid/ready handshake.
// ============================================================================
interface scpe_sample_if #(
    parameter int T_FRAC_BITS = scpe_pkg::T_FRAC_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [T_FRAC_BITS:0] param_t;

    modport source (output valid, output param_t, input ready);
    modport sink   (input valid, input param_t, output ready);
endinterface

// ----- rtl/scpe_point_if.sv -----
// ============================================================================
// Curve point channel
// Carries one evaluated 3D point and its saturation flag per item.
// ============================================================================
interface scpe_point_if #(
    parameter int COORD_WIDTH = scpe_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic                          clipped;

    modport source (output valid, output out_x, output out_y, output out_z,
                    output clipped, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z,
                    input clipped, output ready);
endinterface

// ----- rtl/scpe_cfg_if.sv -----
// ============================================================================
// Configuration write channel
// Carries a register index and write data with a valid/ready handshake.
// ============================================================================
interface scpe_cfg_if #(
    parameter int COORD_WIDTH = scpe_pkg::COORD_WIDTH_DEF
);
    logic                                  valid;
    logic                                  ready;
    logic [scpe_pkg::CFG_INDEX_WIDTH-1:0]  index;
    logic [scpe_pkg::NUM_AXES*COORD_WIDTH-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/scpe_axis.sv -----
// ============================================================================
// Curve point evaluator coordinate lane
// Power-basis coefficients and a pipelined exact Horner evaluation for one
// coordinate, followed by round-half-up and saturation.
// ============================================================================
module scpe_axis #(
    parameter int COORD_WIDTH = scpe_pkg::COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = scpe_pkg::T_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  scpe_pkg::lane_ctrl_t          ctrl,
    input  logic [COORD_WIDTH-1:0]        coord_a,
    input  logic [COORD_WIDTH-1:0]        coord_b,
    input  logic [COORD_WIDTH-1:0]        coord_c,
    input  logic [COORD_WIDTH-1:0]        coord_d,
    input  logic [T_FRAC_BITS:0]          t_first,
    input  logic [T_FRAC_BITS:0]          t_second,
    input  logic [T_FRAC_BITS:0]          t_third,
    output logic signed [COORD_WIDTH-1:0] coord_out,
    output logic                          clip_out
);

    localparam int KW   = COORD_WIDTH + 4;
    localparam int TW   = T_FRAC_BITS + 1;
    localparam int A1W  = KW + TW + 1;
    localparam int L1   = A1W / 2;
    localparam int H1   = A1W - L1;
    localparam int M1LW = L1 + TW;
    localparam int M1HW = H1 + TW + 1;
    localparam int A2W  = A1W + TW + 1;
    localparam int L2   = A2W / 2;
    localparam int H2   = A2W - L2;
    localparam int M2LW = L2 + TW;
    localparam int M2HW = H2 + TW + 1;
    localparam int A3W  = A2W + TW + 1;
    localparam int SH   = 3 * T_FRAC_BITS;
    localparam int VW   = A3W - SH;

    logic signed [KW-1:0] ea, eb, ec, ed;
    logic signed [KW-1:0] k0_next, k1_next, k2_next, k3_next;
    logic signed [KW-1:0] k0_reg, k1_reg, k2_reg, k3_reg;
    logic                 half_next, half_reg;

    logic signed [A1W-1:0]  p3_next, p3_reg;
    logic signed [A1W-1:0]  acc1_next, acc1_reg;
    logic [M1LW-1:0]        m1l_next, m1l_reg;
    logic signed [M1HW-1:0] m1h_next, m1h_reg;
    logic signed [A2W-1:0]  acc2_next, acc2_reg;
    logic [M2LW-1:0]        m2l_next, m2l_reg;
    logic signed [M2HW-1:0] m2h_next, m2h_reg;
    logic signed [A3W-1:0]  acc3_next, acc3_reg;
    logic signed [VW-1:0]   val;
    logic                   pos_ovf, neg_ovf;
    logic signed [COORD_WIDTH-1:0] coord_next, coord_reg;
    logic                   clip_next, clip_reg;

    assign ea = KW'($signed(coord_a));
    assign eb = KW'($signed(coord_b));
    assign ec = KW'($signed(coord_c));
    assign ed = KW'($signed(coord_d));

    // Coefficients of the power basis. For Catmull-Rom they are doubled and
    // the final shift takes one more bit; the rounding carry for that case
    // is folded into the constant term.
    always_comb
    begin
        k0_next   = '0;
        k1_next   = '0;
        k2_next   = '0;
        k3_next   = '0;
        half_next = 1'b0;
        case (ctrl.mode)
            scpe_pkg::MODE_LINEAR:
            begin
                k0_next = ea;
                k1_next = eb - ea;
            end
            scpe_pkg::MODE_QUAD:
            begin
                k0_next = ea;
                k1_next = (eb <<< 1) - (ea <<< 1);
                k2_next = ec - (eb <<< 1) + ea;
            end
            scpe_pkg::MODE_CUBIC:
            begin
                k0_next = ea;
                k1_next = ((eb <<< 1) + eb) - ((ea <<< 1) + ea);
                k2_next = ((ea <<< 1) + ea) - ((eb <<< 2) + (eb <<< 1))
                        + ((ec <<< 1) + ec);
                k3_next = ((eb <<< 1) + eb) - ((ec <<< 1) + ec) + ed - ea;
            end
            scpe_pkg::MODE_CATMULL:
            begin
                k0_next   = (eb <<< 1) + KW'(1);
                k1_next   = ec - ea;
                k2_next   = (ea <<< 1) - ((eb <<< 2) + eb) + (ec <<< 2) - ed;
                k3_next   = ((eb <<< 1) + eb) - ((ec <<< 1) + ec) + ed - ea;
                half_next = 1'b1;
            end
            default:
            begin
                k0_next = '0;
            end
        endcase
    end

    // Horner steps: one multiply stage and one add stage per degree.
    assign p3_next   = k3_reg * $signed({1'b0, t_first});
    assign acc1_next = p3_reg + $signed({{(A1W-KW-T_FRAC_BITS){k2_reg[KW-1]}}, k2_reg,
                                         {T_FRAC_BITS{1'b0}}});
    assign m1l_next  = acc1_reg[L1-1:0] * t_second;
    assign m1h_next  = $signed(acc1_reg[A1W-1:L1]) * $signed({1'b0, t_second});
    assign acc2_next = $signed({m1h_reg, {L1{1'b0}}})
                     + $signed({{(A2W-M1LW){1'b0}}, m1l_reg})
                     + $signed({{(A2W-KW-2*T_FRAC_BITS){k1_reg[KW-1]}}, k1_reg,
                                {(2*T_FRAC_BITS){1'b0}}});
    assign m2l_next  = acc2_reg[L2-1:0] * t_third;
    assign m2h_next  = $signed(acc2_reg[A2W-1:L2]) * $signed({1'b0, t_third});
    assign acc3_next = $signed({m2h_reg, {L2{1'b0}}})
                     + $signed({{(A3W-M2LW){1'b0}}, m2l_reg})
                     + $signed({{(A3W-KW-SH){k0_reg[KW-1]}}, k0_reg, ~half_reg,
                                {(SH-1){1'b0}}});

    // Drop the fraction, then saturate to the coordinate range.
    always_comb
    begin
        if (half_reg)
        begin
            val = {acc3_reg[A3W-1], acc3_reg[A3W-1:SH+1]};
        end
        else
        begin
            val = acc3_reg[A3W-1:SH];
        end
        pos_ovf = !val[VW-1] && (|val[VW-2:COORD_WIDTH-1]);
        neg_ovf = val[VW-1] && !(&val[VW-2:COORD_WIDTH-1]);
        if (pos_ovf)
        begin
            coord_next = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
        else if (neg_ovf)
        begin
            coord_next = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end
        else
        begin
            coord_next = val[COORD_WIDTH-1:0];
        end
        clip_next = pos_ovf || neg_ovf;
    end

    always_ff @(posedge clk)
    begin
        k0_reg   <= k0_next;
        k1_reg   <= k1_next;
        k2_reg   <= k2_next;
        k3_reg   <= k3_next;
        half_reg <= half_next;
        if (ctrl.load[1])
        begin
            p3_reg <= p3_next;
        end
        if (ctrl.load[2])
        begin
            acc1_reg <= acc1_next;
        end
        if (ctrl.load[3])
        begin
            m1l_reg <= m1l_next;
            m1h_reg <= m1h_next;
        end
        if (ctrl.load[4])
        begin
            acc2_reg <= acc2_next;
        end
        if (ctrl.load[5])
        begin
            m2l_reg <= m2l_next;
            m2h_reg <= m2h_next;
        end
        if (ctrl.load[6])
        begin
            acc3_reg <= acc3_next;
        end
        if (ctrl.load[7])
        begin
            coord_reg <= coord_next;
            clip_reg  <= clip_next;
        end
    end

    assign coord_out = coord_reg;
    assign clip_out  = clip_reg;

endmodule

// ----- rtl/spline_curve_point_eval.sv -----
// ============================================================================
// Curve point evaluator
// Evaluates a linear, quadratic Bezier, cubic Bezier or Catmull-Rom curve
// at parameter t and gives the rounded, saturated 3D point.
// ============================================================================
//
//  Channel  Direction  Handshake      Payload
//  -------  ---------  -------------  -----------------------------------
//  cfg      in         valid / ready  index, data (register write)
//  sample   in         valid / ready  param_t (unsigned Q1.16)
//  point    out        valid / ready  out_x, out_y, out_z, clipped
//
// One item enters per cycle while the point channel does not stall. It passes
// an input register, a multiply and an add stage for each of the three Horner
// steps, and a round and saturate stage into the output register: eight stages.
// Each stage has its own valid bit and loads when it is empty or its item moves
// on, so bubbles close up and a stall on the point channel holds every item.
// Reset selects cubic Bezier, clears the points and empties the pipeline.
//
module spline_curve_point_eval #(
    parameter int COORD_WIDTH = scpe_pkg::COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = scpe_pkg::T_FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    scpe_cfg_if.sink     cfg,
    scpe_sample_if.sink  sample,
    scpe_point_if.source point
);

    `include "spline_curve_point_eval_assert.svh"

    localparam int PW = scpe_pkg::NUM_AXES * COORD_WIDTH;
    localparam int NS = scpe_pkg::NUM_STAGES;
    // The parameter is carried through the first five stages.
    localparam int NT = 5;

    // Coordinate range limits.
    localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // Configuration registers.
    scpe_pkg::curve_mode_t mode_reg, mode_next;
    logic [PW-1:0] pa_reg, pa_next;
    logic [PW-1:0] pb_reg, pb_next;
    logic [PW-1:0] pc_reg, pc_next;
    logic [PW-1:0] pd_reg, pd_next;

    // Pipeline control.
    logic [NS-1:0] vld_reg, vld_next;
    logic [NS-1:0] load;
    logic [T_FRAC_BITS:0] t_reg [NT];
    logic [T_FRAC_BITS:0] t_next [NT];

    scpe_pkg::lane_ctrl_t ctrl;
    logic signed [COORD_WIDTH-1:0] lane_coord [scpe_pkg::NUM_AXES];
    logic [scpe_pkg::NUM_AXES-1:0] lane_clip;
    logic [scpe_pkg::NUM_AXES-1:0] lane_at_limit;

    // Register writes; indexes past the list are ignored.
    always_comb
    begin
        mode_next = mode_reg;
        pa_next   = pa_reg;
        pb_next   = pb_reg;
        pc_next   = pc_reg;
        pd_next   = pd_reg;
        if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                scpe_pkg::REG_CURVE_MODE: mode_next = scpe_pkg::curve_mode_t'(cfg.data[1:0]);
                scpe_pkg::REG_POINT_A:    pa_next   = cfg.data;
                scpe_pkg::REG_POINT_B:    pb_next   = cfg.data;
                scpe_pkg::REG_POINT_C:    pc_next   = cfg.data;
                scpe_pkg::REG_POINT_D:    pd_next   = cfg.data;
                default:                  mode_next = mode_reg;
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    // A stage loads when it is empty or when its item moves on.
    always_comb
    begin
        load[NS-1] = !vld_reg[NS-1] || point.ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            load[i] = !vld_reg[i] || load[i+1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (load[0])
        begin
            vld_next[0] = sample.valid;
        end
        for (int i = 1; i < NS; i++)
        begin
            if (load[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NT; i++)
        begin
            t_next[i] = t_reg[i];
        end
        if (load[0])
        begin
            t_next[0] = sample.param_t;
        end
        for (int i = 1; i < NT; i++)
        begin
            if (load[i])
            begin
                t_next[i] = t_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= scpe_pkg::MODE_RESET;
            pa_reg   <= '0;
            pb_reg   <= '0;
            pc_reg   <= '0;
            pd_reg   <= '0;
            vld_reg  <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
            pc_reg   <= pc_next;
            pd_reg   <= pd_next;
            vld_reg  <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NT; i++)
        begin
            t_reg[i] <= t_next[i];
        end
    end

    assign sample.ready = load[0];

    assign ctrl.mode = mode_reg;
    assign ctrl.load = load;

    // One lane per coordinate; x sits in the low bits of each point register.
    for (genvar g = 0; g < scpe_pkg::NUM_AXES; g++)
    begin : g_axis
        scpe_axis #(
            .COORD_WIDTH (COORD_WIDTH),
            .T_FRAC_BITS (T_FRAC_BITS)
        ) u_axis (
            .clk       (clk),
            .ctrl      (ctrl),
            .coord_a   (pa_reg[g*COORD_WIDTH +: COORD_WIDTH]),
            .coord_b   (pb_reg[g*COORD_WIDTH +: COORD_WIDTH]),
            .coord_c   (pc_reg[g*COORD_WIDTH +: COORD_WIDTH]),
            .coord_d   (pd_reg[g*COORD_WIDTH +: COORD_WIDTH]),
            .t_first   (t_reg[0]),
            .t_second  (t_reg[2]),
            .t_third   (t_reg[4]),
            .coord_out (lane_coord[g]),
            .clip_out  (lane_clip[g])
        );
    end

    assign point.valid   = vld_reg[NS-1];
    assign point.out_x   = lane_coord[0];
    assign point.out_y   = lane_coord[1];
    assign point.out_z   = lane_coord[2];
    assign point.clipped = |lane_clip;

    // Marks the coordinates that sit at either end of the range.
    always_comb
    begin
        for (int i = 0; i < scpe_pkg::NUM_AXES; i++)
        begin
            lane_at_limit[i] = (lane_coord[i] == C_MAX) || (lane_coord[i] == C_MIN);
        end
    end

    // A blocked stage keeps its item.
    `SCPE_ASSERT_NEXT(a_stage_hold, clk, rst_n, vld_reg[3] && !load[3], vld_reg[3])
    // An accepted item always lands in the input register.
    `SCPE_ASSERT_NEXT(a_accept_lands, clk, rst_n, sample.valid && sample.ready, vld_reg[0])
    // A taken result with nothing behind it leaves the output empty.
    `SCPE_ASSERT_NEXT(a_out_drains, clk, rst_n, point.valid && point.ready && !vld_reg[NS-2], !point.valid)
    // A clipped point has a coordinate sitting at a range limit.
    `SCPE_ASSERT_SAME(a_clip_limit, clk, rst_n, point.valid && point.clipped, |lane_at_limit)

endmodule

// ----- tb/tb.sv -----
// ============================================================================
// Curve point evaluator testbench
// Drives parameter samples through spline_curve_point_eval under all four
// curve modes and checks each point against a typed-in one or an exact integer
// evaluation of the curve polynomial, with random stalls on both channels.
// ============================================================================
module tb;

    import scpe_pkg::*;

    localparam int CW = COORD_WIDTH_DEF;
    localparam int TF = T_FRAC_BITS_DEF;
    localparam int TW = TF + 1;
    localparam int PW = NUM_AXES * CW;

    // Index with no register behind it; a write there must change nothing.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 3'd7;

    localparam int RANDOM_ITEMS = 750;
    localparam int LONG_HOLD    = 60;
    localparam int CYCLE_LIMIT  = 300000;

    // Expected point. Packed with z on top and x just above the flag, so a
    // packed control point followed by a flag bit reads as a point directly.
    typedef struct packed {
        logic signed [CW-1:0] z;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] x;
        logic                 clipped;
    } point_t;

    // One row of the directed stimulus: the curve it needs, the parameter,
    // and a typed-in point where the answer is obvious from the curve shape.
    typedef struct packed {
        curve_mode_t   mode;
        logic [PW-1:0] pa;
        logic [PW-1:0] pb;
        logic [PW-1:0] pc;
        logic [PW-1:0] pd;
        logic [TF:0]   t;
        logic          known;
        point_t        want;
    } curve_case_t;

    localparam logic [PW-1:0] P_ZERO = '0;
    localparam logic [PW-1:0] P_MAX  = {3{16'h7FFF}};
    localparam logic [PW-1:0] P_MIN  = {3{16'h8000}};
    localparam logic [PW-1:0] PA     = 48'hF380_0C40_0100;
    localparam logic [PW-1:0] PB     = 48'h0A00_FE00_2000;
    localparam logic [PW-1:0] PC     = 48'h1234_8765_0FF0;
    localparam logic [PW-1:0] PD     = 48'h7FFF_8000_5A5A;
    localparam logic [TF:0]   T_ONE  = 17'd65536;
    localparam logic [TF:0]   T_TOP  = 17'h1FFFF;
    localparam point_t        NO_PT  = '0;

    // The first two rows match the reset configuration, so no register is
    // written before them and they check the reset values. Curve ends give
    // exact points: t = 0 lands on the first point (on b for Catmull-Rom),
    // t = 1 on the last (on c for Catmull-Rom). Extrapolation past t = 1 on
    // a full-range line has to saturate every coordinate.
    localparam curve_case_t DIRECTED_CASES [23] = '{
        '{MODE_CUBIC,   P_ZERO, P_ZERO, P_ZERO, P_ZERO, 17'd0,     1'b1, {P_ZERO, 1'b0}},
        '{MODE_CUBIC,   P_ZERO, P_ZERO, P_ZERO, P_ZERO, T_ONE,     1'b1, {P_ZERO, 1'b0}},
        '{MODE_LINEAR,  PA,     PB,     PC,     PD,     17'd0,     1'b1, {PA, 1'b0}},
        '{MODE_LINEAR,  PA,     PB,     PC,     PD,     T_ONE,     1'b1, {PB, 1'b0}},
        '{MODE_LINEAR,  PA,     PB,     PC,     PD,     17'd32768, 1'b0, NO_PT},
        '{MODE_LINEAR,  P_MAX,  P_MIN,  PC,     PD,     17'd0,     1'b1, {P_MAX, 1'b0}},
        '{MODE_LINEAR,  P_MAX,  P_MIN,  PC,     PD,     T_ONE,     1'b1, {P_MIN, 1'b0}},
        '{MODE_LINEAR,  P_MAX,  P_MIN,  PC,     PD,     T_TOP,     1'b1, {P_MIN, 1'b1}},
        '{MODE_LINEAR,  P_MIN,  P_MAX,  PC,     PD,     T_TOP,     1'b1, {P_MAX, 1'b1}},
        '{MODE_QUAD,    PA,     PB,     PC,     PD,     17'd0,     1'b1, {PA, 1'b0}},
        '{MODE_QUAD,    PA,     PB,     PC,     PD,     T_ONE,     1'b1, {PC, 1'b0}},
        '{MODE_QUAD,    PA,     PB,     PC,     PD,     17'd16384, 1'b0, NO_PT},
        '{MODE_QUAD,    P_MAX,  P_MIN,  P_MAX,  PD,     17'd32768, 1'b0, NO_PT},
        '{MODE_QUAD,    P_MAX,  P_MIN,  P_MAX,  PD,     T_TOP,     1'b0, NO_PT},
        '{MODE_CUBIC,   PA,     PB,     PC,     PD,     17'd0,     1'b1, {PA, 1'b0}},
        '{MODE_CUBIC,   PA,     PB,     PC,     PD,     T_ONE,     1'b1, {PD, 1'b0}},
        '{MODE_CUBIC,   PA,     PB,     PC,     PD,     17'd40000, 1'b0, NO_PT},
        '{MODE_CUBIC,   P_MIN,  P_MAX,  P_MIN,  P_MAX,  17'd100000, 1'b0, NO_PT},
        '{MODE_CATMULL, PA,     PB,     PC,     PD,     17'd0,     1'b1, {PB, 1'b0}},
        '{MODE_CATMULL, PA,     PB,     PC,     PD,     T_ONE,     1'b1, {PC, 1'b0}},
        '{MODE_CATMULL, PA,     PB,     PC,     PD,     17'd1,     1'b0, NO_PT},
        '{MODE_CATMULL, P_MAX,  P_MIN,  P_MAX,  P_MIN,  17'd32768, 1'b0, NO_PT},
        '{MODE_CATMULL, P_MIN,  P_MAX,  P_MIN,  P_MAX,  T_TOP,     1'b0, NO_PT}
    };

    logic clk;
    logic rst_n;

    scpe_cfg_if    cfg_ch ();
    scpe_sample_if sample_ch ();
    scpe_point_if  point_ch ();

    spline_curve_point_eval i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .sample (sample_ch),
        .point  (point_ch)
    );

    // Shadow copy of the configuration registers, updated at each accepted
    // write. The predictor reads only this copy.
    curve_mode_t   shadow_mode = MODE_RESET;
    logic [PW-1:0] shadow_pts [4] = '{P_ZERO, P_ZERO, P_ZERO, P_ZERO};

    // Points still owed by the block, oldest first.
    point_t points_due [$];

    int unsigned mismatches   = 0;
    int unsigned cycle_count  = 0;
    int unsigned src_gap_max  = 0;
    int unsigned sink_gap_max = 0;
    bit          hold_off_req = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Exact evaluation of the curve at t. Each coordinate polynomial is
    // written in power form and evaluated by Horner's rule in 128-bit
    // integers, scaled so that no fraction bit is lost. The sum is rounded
    // once (half toward plus infinity) by adding half a step before the
    // arithmetic shift, then saturated. Catmull-Rom coefficients are kept
    // doubled to stay integral, so that mode shifts one bit further.
    function automatic point_t curve_point_at(input logic [TF:0] t);
        logic signed [CW-1:0]  pa;
        logic signed [CW-1:0]  pb;
        logic signed [CW-1:0]  pc;
        logic signed [CW-1:0]  pd;
        longint                a;
        longint                b;
        longint                c;
        longint                d;
        longint                k [4];
        logic signed [127:0]   tw;
        logic signed [127:0]   acc;
        logic signed [127:0]   term;
        int                    shift;
        logic signed [CW-1:0]  lane [NUM_AXES];
        point_t                p;
        longint                hi_lim;
        longint                lo_lim;

        hi_lim    = (longint'(1) <<< (CW - 1)) - 1;
        lo_lim    = -(longint'(1) <<< (CW - 1));
        tw        = 128'(t);
        p.clipped = 1'b0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            pa = shadow_pts[0][i*CW +: CW];
            pb = shadow_pts[1][i*CW +: CW];
            pc = shadow_pts[2][i*CW +: CW];
            pd = shadow_pts[3][i*CW +: CW];
            a  = longint'(pa);
            b  = longint'(pb);
            c  = longint'(pc);
            d  = longint'(pd);
            k  = '{0, 0, 0, 0};
            shift = 3 * TF;
            case (shadow_mode)
                MODE_LINEAR:
                begin
                    k[0] = a;
                    k[1] = b - a;
                end
                MODE_QUAD:
                begin
                    k[0] = a;
                    k[1] = 2 * b - 2 * a;
                    k[2] = c - 2 * b + a;
                end
                MODE_CUBIC:
                begin
                    k[0] = a;
                    k[1] = 3 * b - 3 * a;
                    k[2] = 3 * a - 6 * b + 3 * c;
                    k[3] = -a + 3 * b - 3 * c + d;
                end
                default:
                begin
                    k[0] = 2 * b;
                    k[1] = c - a;
                    k[2] = 2 * a - 5 * b + 4 * c - d;
                    k[3] = -a + 3 * b - 3 * c + d;
                    shift = 3 * TF + 1;
                end
            endcase
            acc = 128'(k[3]);
            for (int j = 2; j >= 0; j--)
            begin
                term = 128'(k[j]);
                acc  = acc * tw + (term <<< ((3 - j) * TF));
            end
            acc = (acc + (128'sd1 <<< (shift - 1))) >>> shift;
            if (acc > hi_lim)
            begin
                acc       = 128'(hi_lim);
                p.clipped = 1'b1;
            end
            if (acc < lo_lim)
            begin
                acc       = 128'(lo_lim);
                p.clipped = 1'b1;
            end
            lane[i] = acc[CW-1:0];
        end
        p.x = lane[0];
        p.y = lane[1];
        p.z = lane[2];
        return p;
    endfunction

    // A random control point. Full-range coordinates mostly saturate the
    // curves that overshoot, so smaller values and pure extremes are mixed
    // in; style 3 picks the kind afresh for every coordinate.
    function automatic logic [PW-1:0] rand_point(input int unsigned style);
        logic [PW-1:0] p;
        int unsigned   kind;

        for (int i = 0; i < NUM_AXES; i++)
        begin
            kind = (style == 3) ? $urandom_range(0, 2) : style;
            case (kind)
                0:       p[i*CW +: CW] = CW'($urandom);
                1:       p[i*CW +: CW] = CW'($urandom_range(0, 4095) - 2048);
                default:
                begin
                    case ($urandom_range(0, 2))
                        0:       p[i*CW +: CW] = 16'h7FFF;
                        1:       p[i*CW +: CW] = 16'h8000;
                        default: p[i*CW +: CW] = 16'h0000;
                    endcase
                end
            endcase
        end
        return p;
    endfunction

    // One register write. Valid is left high so that back-to-back writes do
    // not toggle it within a step; the caller lowers it after the batch.
    task automatic cfg_write(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [PW-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        case (idx)
            REG_CURVE_MODE: shadow_mode   = curve_mode_t'(val[1:0]);
            REG_POINT_A:    shadow_pts[0] = val;
            REG_POINT_B:    shadow_pts[1] = val;
            REG_POINT_C:    shadow_pts[2] = val;
            REG_POINT_D:    shadow_pts[3] = val;
            default:        ;
        endcase
        @(negedge clk);
    endtask

    // Stops offering samples and waits until every owed point has come out,
    // then lets the pipeline depth pass once more. Every sample yields one
    // point, so an empty list means an empty pipeline.
    task automatic settle_pipeline();
        sample_ch.valid <= 1'b0;
        while (points_due.size() != 0)
            @(posedge clk);
        repeat (NUM_STAGES + 2) @(posedge clk);
        @(negedge clk);
    endtask

    // Reconfigures the curve while the block is idle. The mode register gets
    // random junk above its two bits, which the block must ignore.
    task automatic load_curve(input curve_mode_t mode, input logic [PW-1:0] pa,
                              input logic [PW-1:0] pb, input logic [PW-1:0] pc,
                              input logic [PW-1:0] pd);
        logic [PW-1:0] mode_word;

        settle_pipeline();
        mode_word      = PW'({$urandom, $urandom});
        mode_word[1:0] = mode;
        cfg_write(REG_CURVE_MODE, mode_word);
        cfg_write(REG_POINT_A, pa);
        cfg_write(REG_POINT_B, pb);
        cfg_write(REG_POINT_C, pc);
        cfg_write(REG_POINT_D, pd);
        if ($urandom_range(0, 3) == 0)
            cfg_write(REG_UNUSED, PW'({$urandom, $urandom}));
        cfg_ch.valid <= 1'b0;
    endtask

    // Offers one parameter sample after a random gap and records the point
    // it must produce, either typed in by the caller or from the predictor.
    task automatic send_sample(input logic [TF:0] t, input bit typed,
                               input point_t typed_pt);
        int unsigned gap;

        gap = $urandom_range(0, src_gap_max);
        if (gap != 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid   <= 1'b1;
        sample_ch.param_t <= t;
        do
            @(posedge clk);
        while (!(sample_ch.valid && sample_ch.ready));
        points_due.insert(points_due.size(), typed ? typed_pt : curve_point_at(t));
        @(negedge clk);
    endtask

    // Parameter mix for the random part: mostly inside [0, 1], a share of
    // exact ends, and some extrapolation up to the top of the field.
    function automatic logic [TF:0] rand_param();
        int unsigned pick;

        pick = $urandom_range(0, 99);
        if (pick < 80)
            return TW'($urandom_range(0, 65536));
        if (pick < 88)
            return ($urandom_range(0, 1) == 0) ? 17'd0 : T_ONE;
        return TW'($urandom_range(65537, 131071));
    endfunction

    // Point channel receiver. Before each item it holds ready low for a
    // random number of cycles; once, on request, it holds off for a long
    // stretch so that the pipeline fills and the sample channel backs up.
    initial
    begin : point_sink
        int unsigned gap;

        point_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            gap = $urandom_range(0, sink_gap_max);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                gap          = LONG_HOLD;
            end
            if (gap != 0)
            begin
                point_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            point_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(point_ch.valid && point_ch.ready));
            @(negedge clk);
        end
    end

    // Checks every accepted point against the oldest owed one.
    always @(posedge clk)
    begin : point_check
        point_t want;

        if (rst_n && point_ch.valid && point_ch.ready)
        begin
            if (points_due.size() == 0)
            begin
                $error("point item with no sample waiting for it");
                mismatches++;
            end
            else
            begin
                want = points_due.pop_front();
                if (point_ch.out_x !== want.x)
                begin
                    $error("out_x: expected %0d, got %0d", want.x, point_ch.out_x);
                    mismatches++;
                end
                if (point_ch.out_y !== want.y)
                begin
                    $error("out_y: expected %0d, got %0d", want.y, point_ch.out_y);
                    mismatches++;
                end
                if (point_ch.out_z !== want.z)
                begin
                    $error("out_z: expected %0d, got %0d", want.z, point_ch.out_z);
                    mismatches++;
                end
                if (point_ch.clipped !== want.clipped)
                begin
                    $error("clipped: expected %0d, got %0d", want.clipped,
                           point_ch.clipped);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** spline_curve_point_eval: FAILED **");
            $finish;
        end
    end

    initial
    begin : stimulus
        curve_case_t   row;
        int unsigned   sent;
        int unsigned   phase;
        int unsigned   burst;
        int unsigned   style;
        curve_mode_t   mode;

        rst_n             = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = REG_CURVE_MODE;
        cfg_ch.data       = '0;
        sample_ch.valid   = 1'b0;
        sample_ch.param_t = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part. The curve is reloaded only when a row asks for a
        // different one, so the leading rows run on the reset values.
        src_gap_max  = 3;
        sink_gap_max = 3;
        foreach (DIRECTED_CASES[i])
        begin
            row = DIRECTED_CASES[i];
            if (row.mode != shadow_mode || row.pa != shadow_pts[0] ||
                row.pb != shadow_pts[1] || row.pc != shadow_pts[2] ||
                row.pd != shadow_pts[3])
                load_curve(row.mode, row.pa, row.pb, row.pc, row.pd);
            send_sample(row.t, row.known, row.want);
        end

        // Random part: a fresh curve per phase, then a burst of samples.
        // Each side is either busy-free or idles for a random gap before each item,
        // so both gap-free stretches and gaps at every pipeline phase occur.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            mode  = curve_mode_t'($urandom_range(0, 3));
            style = $urandom_range(0, 3);
            load_curve(mode, rand_point(style), rand_point(style),
                       rand_point(style), rand_point(style));
            src_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : 10;
            sink_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
            burst        = $urandom_range(10, 40);
            if (phase == 2)
            begin
                // Back-pressure phase: the sender streams with no gaps while
                // the receiver sits out a long stall.
                src_gap_max  = 0;
                hold_off_req = 1'b1;
                burst        = 40;
            end
            repeat (burst)
            begin
                send_sample(rand_param(), 1'b0, NO_PT);
                sent++;
            end
            phase++;
        end

        settle_pipeline();
        if (mismatches == 0 && points_due.size() == 0)
            $display("** spline_curve_point_eval: PASSED **");
        else
            $display("** spline_curve_point_eval: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/scpe_pkg.sv
rtl/scpe_sample_if.sv
rtl/scpe_point_if.sv
rtl/scpe_cfg_if.sv
rtl/scpe_axis.sv
rtl/spline_curve_point_eval.sv
tb/tb.sv
